FILE: rtl/tksd_pkg.sv
// tksd_pkg: types, key codes and decode functions of the terminal key sequence decoder
// no dependencies; used by the channel interfaces and the core

package tksd_pkg;

  typedef logic [7:0] rx_byte_t;
  typedef logic [8:0] key_code_t;
  typedef logic [15:0] param_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_SS3  = 2'd2,
    PH_CSI  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    PP_FIRST  = 2'd0,
    PP_SECOND = 2'd1,
    PP_DONE   = 2'd2
  } param_phase_e;

  typedef struct packed {
    param_phase_e pp;
    param_t       p1;
    param_t       p2;
    logic         seen1;
    logic         seen2;
  } params_t;

  localparam params_t PARAMS_RST = '{pp: PP_FIRST, p1: 16'd1, p2: 16'd1,
                                     seen1: 1'b0, seen2: 1'b0};

  localparam rx_byte_t CH_ESC   = 8'h1B;
  localparam rx_byte_t CH_O     = 8'h4F;
  localparam rx_byte_t CH_LBR   = 8'h5B;
  localparam rx_byte_t CH_TILDE = 8'h7E;
  localparam rx_byte_t CH_CARET = 8'h5E;
  localparam rx_byte_t CH_SEMI  = 8'h3B;
  localparam rx_byte_t CH_ZERO  = 8'h30;
  localparam rx_byte_t CH_NINE  = 8'h39;
  localparam rx_byte_t CH_H     = 8'h48;
  localparam rx_byte_t CH_F     = 8'h46;
  localparam rx_byte_t CH_A     = 8'h41;
  localparam rx_byte_t CH_B     = 8'h42;
  localparam rx_byte_t CH_C     = 8'h43;
  localparam rx_byte_t CH_D     = 8'h44;
  localparam rx_byte_t FINAL_LO = 8'h40;
  localparam rx_byte_t FINAL_HI = 8'h7E;

  localparam key_code_t KEY_ESC       = 9'd27;
  localparam key_code_t KEY_LEFT      = 9'd256;
  localparam key_code_t KEY_RIGHT     = 9'd257;
  localparam key_code_t KEY_DOWN      = 9'd258;
  localparam key_code_t KEY_UP        = 9'd259;
  localparam key_code_t KEY_PGUP      = 9'd260;
  localparam key_code_t KEY_PGDN      = 9'd261;
  localparam key_code_t KEY_HOME      = 9'd262;
  localparam key_code_t KEY_END       = 9'd263;
  localparam key_code_t KEY_CTRL_HOME = 9'd264;
  localparam key_code_t KEY_CTRL_END  = 9'd265;
  localparam key_code_t KEY_DELETE    = 9'd266;

  localparam logic [19:0] PARAM_SAT = 20'd65535;

  function automatic param_t add_digit(param_t value, logic seen, logic [3:0] d);
    logic [19:0] v;
    v = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {16'd0, d};
    if (!seen) begin
      return {12'd0, d};
    end
    return (v > PARAM_SAT) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic key_code_t decode_ss3(rx_byte_t b);
    key_code_t k;
    unique case (b)
      CH_H:    k = KEY_HOME;
      CH_F:    k = KEY_END;
      CH_A:    k = KEY_UP;
      CH_B:    k = KEY_DOWN;
      CH_C:    k = KEY_RIGHT;
      CH_D:    k = KEY_LEFT;
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic key_code_t decode_csi(rx_byte_t b, param_t p1, param_t p2);
    param_t    pm1;
    logic      ctrl;
    key_code_t home;
    key_code_t fend;
    key_code_t k;
    pm1  = p2 - 16'd1;
    ctrl = pm1[2];
    home = ctrl ? KEY_CTRL_HOME : KEY_HOME;
    fend = ctrl ? KEY_CTRL_END : KEY_END;
    unique case (b)
      CH_H: k = home;
      CH_F: k = fend;
      CH_A: k = KEY_UP;
      CH_B: k = KEY_DOWN;
      CH_C: k = KEY_RIGHT;
      CH_D: k = KEY_LEFT;
      CH_TILDE: begin
        unique case (p1)
          16'd1, 16'd7: k = home;
          16'd4, 16'd8: k = fend;
          16'd3:        k = KEY_DELETE;
          16'd5:        k = KEY_PGUP;
          16'd6:        k = KEY_PGDN;
          default:      k = KEY_ESC;
        endcase
      end
      CH_CARET: begin
        priority if (p1 == 16'd7) begin
          k = KEY_CTRL_HOME;
        end else if (p1 == 16'd8) begin
          k = KEY_CTRL_END;
        end else begin
          k = KEY_ESC;
        end
      end
      default: k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/tksd_if.sv
// tksd_in_if and tksd_out_if: valid/ready channels of the key sequence decoder
// depends on tksd_pkg for the payload types

interface tksd_in_if;
  logic                valid;
  logic                ready;
  tksd_pkg::rx_byte_t  rx_byte;
  logic                timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface tksd_out_if;
  logic                valid;
  logic                ready;
  tksd_pkg::key_code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

FILE: rtl/terminal_key_sequence_decoder_core.sv
// terminal_key_sequence_decoder_core: byte/timeout parser for CSI and SS3 key escapes
// depends on tksd_pkg and the tksd_in_if / tksd_out_if channel interfaces
//
// usage:
//   in_i  takes one word per handshake: a terminal byte, or a timeout event
//         (timed_out high, byte ignored)
//   out_o gives one key code word for each byte or timeout that completes a key;
//         bytes inside an escape sequence give no word
//   a word is accepted on a rising edge with valid and ready both high
// timing:
//   one input word per cycle sustained until both output entries are full; the key
//   code appears on out_o from the result register fed by the parser state
//   a two-entry output buffer (result register plus skid) keeps in_i ready while
//   one result waits; in_i drops ready only when both entries are full
// reset:
//   rst_ni low clears the parser to idle, default parameters and empty buffer
// stall:
//   while out_o is stalled results are held in order, none dropped

module terminal_key_sequence_decoder_core #(
  parameter int MAX_COLLECT = 23
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tksd_in_if.sink    in_i,
  tksd_out_if.source out_o
);
  import tksd_pkg::*;

  localparam int CntW = $clog2(MAX_COLLECT);

  phase_e          phase_q, phase_d;
  params_t         par_q, par_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic      out_vld_q, out_vld_d;
  key_code_t out_key_q, out_key_d;
  logic      skid_vld_q, skid_vld_d;
  key_code_t skid_key_q, skid_key_d;

  logic      accept;
  logic      res_vld;
  key_code_t res_key;
  logic      fin;
  logic      is_digit;
  logic      is_final;
  logic [3:0] digit;
  rx_byte_t  b;
  rx_byte_t  dsub;

  assign b        = in_i.rx_byte;
  assign accept   = in_i.valid & in_i.ready;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_final = (b >= FINAL_LO) && (b <= FINAL_HI);
  assign dsub     = b - CH_ZERO;
  assign digit    = dsub[3:0];

  // parser step
  always_comb begin
    phase_d = phase_q;
    par_d   = par_q;
    cnt_d   = cnt_q;
    res_vld = 1'b0;
    res_key = KEY_ESC;
    fin     = 1'b0;
    if (accept) begin
      if (phase_q == PH_IDLE) begin
        if (!in_i.timed_out) begin
          if (b == CH_ESC) begin
            phase_d = PH_ESC;
          end else begin
            res_vld = 1'b1;
            res_key = {1'b0, b};
          end
        end
      end else if (in_i.timed_out) begin
        fin = 1'b1;
      end else begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_ESC: begin
            priority if (b == CH_O) begin
              phase_d = PH_SS3;
            end else if (b == CH_LBR) begin
              phase_d = PH_CSI;
              par_d   = PARAMS_RST;
              cnt_d   = '0;
            end else begin
              fin = 1'b1;
            end
          end
          PH_SS3: begin
            fin     = 1'b1;
            res_key = decode_ss3(b);
          end
          PH_CSI: begin
            if (is_final) begin
              fin     = 1'b1;
              res_key = decode_csi(b, par_q.p1, par_q.p2);
            end else begin
              unique case (par_q.pp)
                PP_FIRST: begin
                  priority if (is_digit) begin
                    par_d.p1    = add_digit(par_q.p1, par_q.seen1, digit);
                    par_d.seen1 = 1'b1;
                  end else if (b == CH_SEMI && par_q.seen1) begin
                    par_d.pp = PP_SECOND;
                  end else begin
                    par_d.pp = PP_DONE;
                  end
                end
                PP_SECOND: begin
                  if (is_digit) begin
                    par_d.p2    = add_digit(par_q.p2, par_q.seen2, digit);
                    par_d.seen2 = 1'b1;
                  end else begin
                    par_d.pp = PP_DONE;
                  end
                end
                default: ;
              endcase
              if (cnt_q == CntW'(MAX_COLLECT - 1)) begin
                fin = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end
        endcase
      end
      if (fin) begin
        phase_d = PH_IDLE;
        par_d   = PARAMS_RST;
        cnt_d   = '0;
        res_vld = 1'b1;
      end
    end
  end

  // output register plus skid entry
  assign in_i.ready     = !skid_vld_q;
  assign out_o.valid    = out_vld_q;
  assign out_o.key_code = out_key_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_key_d  = out_key_q;
    skid_vld_d = skid_vld_q;
    skid_key_d = skid_key_q;
    if (out_o.ready && out_vld_q) begin
      out_vld_d  = skid_vld_q;
      out_key_d  = skid_key_q;
      skid_vld_d = 1'b0;
    end
    if (res_vld) begin
      if (!out_vld_d) begin
        out_vld_d = 1'b1;
        out_key_d = res_key;
      end else begin
        skid_vld_d = 1'b1;
        skid_key_d = res_key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      par_q      <= PARAMS_RST;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      par_q      <= par_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    skid_key_q <= skid_key_d;
  end

endmodule
